FILE: rtl/pikt_pkg.sv
// pikt_pkg: sizes, codes, item and entry types and the priority encoder
// of the process id keyed table. No dependencies.
`default_nettype none

package pikt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SLOT_W = 6;
  localparam int ID_W   = 32;
  localparam int TS_W   = 64;
  localparam int EXEC_W = 16;
  localparam logic [EXEC_W-1:0] EXEC_MAX = '1;

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_FIND   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    STS_INSERTED = 3'd0,
    STS_UPDATED  = 3'd1,
    STS_FULL     = 3'd2,
    STS_REMOVED  = 3'd3,
    STS_NOTFOUND = 3'd4,
    STS_FOUND    = 3'd5,
    STS_CLEARED  = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ENC,
    S_RD
  } state_t;

  typedef struct packed {
    action_t         action;
    logic [ID_W-1:0] pid;
    logic [ID_W-1:0] ppid;
    logic [ID_W-1:0] uid;
    logic [ID_W-1:0] gid;
    logic [TS_W-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [ID_W-1:0]   parent_id;
    logic [ID_W-1:0]   user_id;
    logic [ID_W-1:0]   group_id;
    logic [TS_W-1:0]   start_time;
    logic [TS_W-1:0]   last_activity;
    logic [EXEC_W-1:0] run_count;
  } out_item_t;

  // payload word of one table entry; the key lives in flops for the match
  typedef struct packed {
    logic [ID_W-1:0]   parent;
    logic [ID_W-1:0]   user;
    logic [ID_W-1:0]   group;
    logic [TS_W-1:0]   start;
    logic [TS_W-1:0]   activity;
    logic [EXEC_W-1:0] execs;
  } entry_t;

  // index of the lowest set bit, zero if none
  function automatic logic [IDX_W-1:0] lowest_set(input logic [TABLE_ENTRIES-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pikt_if.sv
// pikt_in_if / pikt_out_if: valid-ready channels carrying the request
// and result beats of the process id keyed table. No dependencies.
`default_nettype none

interface pikt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] pid;
  logic [31:0] ppid;
  logic [31:0] uid;
  logic [31:0] gid;
  logic [63:0] timestamp;

  modport source (output valid, action, pid, ppid, uid, gid, timestamp, input ready);
  modport sink   (input valid, action, pid, ppid, uid, gid, timestamp, output ready);
endinterface

interface pikt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  slot;
  logic [31:0] parent_id;
  logic [31:0] user_id;
  logic [31:0] group_id;
  logic [63:0] start_time;
  logic [63:0] last_activity;
  logic [15:0] run_count;

  modport source (output valid, status, slot, parent_id, user_id, group_id, start_time,
                  last_activity, run_count, input ready);
  modport sink   (input valid, status, slot, parent_id, user_id, group_id, start_time,
                  last_activity, run_count, output ready);
endinterface

`default_nettype wire

FILE: rtl/process_id_keyed_table_top.sv
// Flow: the request beat registers the request and its key match; insert,
// remove, miss, full and clear then load the result register, while an update
// or a find hit first reads the payload memory. A stalled result output holds
// the request. One request in flight: no new beat until the result is loaded.
// Reset: valid bits clear, payload memory is left as is.
// Uses pikt_pkg, pikt_in_if, pikt_out_if.
`default_nettype none

module process_id_keyed_table_top (
  input  logic        clk,
  input  logic        rst_n,
  pikt_in_if.sink     in_if,
  pikt_out_if.source  out_if
);
  import pikt_pkg::*;

  state_t                 state_r, state_nxt;
  in_item_t               req_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [TABLE_ENTRIES-1:0] hit_r;
  logic [ID_W-1:0]        key_r [TABLE_ENTRIES];
  logic [IDX_W-1:0]       idx_r;

  entry_t                 mem [TABLE_ENTRIES];
  entry_t                 rd_q;

  out_item_t              out_data_r, out_nxt;
  logic                   out_valid_r;

  logic                   accept, fire;
  logic                   hit_any, free_any;
  logic [IDX_W-1:0]       hit_idx, free_idx;
  logic [TABLE_ENTRIES-1:0] hit_nxt;

  logic                   mem_we, rd_en, key_we, set_valid, clr_valid, clr_all, out_load;
  logic [IDX_W-1:0]       mem_wa, vld_idx;
  entry_t                 mem_wd;

  assign in_if.ready = (state_r == S_IDLE);
  assign accept      = in_if.valid && in_if.ready;
  assign fire        = !out_valid_r || out_if.ready;

  // key match against every valid entry, registered at the request beat
  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_nxt[i] = valid_r[i] && (key_r[i] == in_if.pid);
    end
  end

  assign hit_any  = |hit_r;
  assign hit_idx  = lowest_set(hit_r);
  assign free_any = ~&valid_r;
  assign free_idx = lowest_set(~valid_r);

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_wa    = idx_r;
    mem_wd    = rd_q;
    rd_en     = 1'b0;
    key_we    = 1'b0;
    set_valid = 1'b0;
    clr_valid = 1'b0;
    clr_all   = 1'b0;
    vld_idx   = hit_idx;
    out_load  = 1'b0;
    out_nxt   = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_ENC;
      end
      S_ENC: begin
        rd_en = 1'b1;
        unique case (req_r.action)
          ACT_ADD: begin
            if (hit_any) begin
              state_nxt = S_RD;
            end else if (fire) begin
              state_nxt = S_IDLE;
              out_load  = 1'b1;
              if (free_any) begin
                mem_we          = 1'b1;
                mem_wa          = free_idx;
                mem_wd.parent   = req_r.ppid;
                mem_wd.user     = req_r.uid;
                mem_wd.group    = req_r.gid;
                mem_wd.start    = req_r.timestamp;
                mem_wd.activity = req_r.timestamp;
                mem_wd.execs    = EXEC_W'(1);
                key_we          = 1'b1;
                set_valid       = 1'b1;
                vld_idx         = free_idx;
                out_nxt.status    = STS_INSERTED;
                out_nxt.slot      = SLOT_W'(free_idx);
                out_nxt.run_count = EXEC_W'(1);
              end else begin
                out_nxt.status = STS_FULL;
              end
            end
          end
          ACT_FIND: begin
            if (hit_any) begin
              state_nxt = S_RD;
            end else if (fire) begin
              state_nxt      = S_IDLE;
              out_load       = 1'b1;
              out_nxt.status = STS_NOTFOUND;
            end
          end
          ACT_REMOVE: begin
            if (fire) begin
              state_nxt = S_IDLE;
              out_load  = 1'b1;
              if (hit_any) begin
                clr_valid      = 1'b1;
                out_nxt.status = STS_REMOVED;
                out_nxt.slot   = SLOT_W'(hit_idx);
              end else begin
                out_nxt.status = STS_NOTFOUND;
              end
            end
          end
          ACT_CLEAR: begin
            if (fire) begin
              state_nxt      = S_IDLE;
              out_load       = 1'b1;
              clr_all        = 1'b1;
              out_nxt.status = STS_CLEARED;
            end
          end
          default: ;
        endcase
      end
      S_RD: begin
        if (fire) begin
          state_nxt    = S_IDLE;
          out_load     = 1'b1;
          out_nxt.slot = SLOT_W'(idx_r);
          if (req_r.action == ACT_ADD) begin
            mem_we          = 1'b1;
            mem_wd.parent   = req_r.ppid;
            mem_wd.user     = req_r.uid;
            mem_wd.group    = req_r.gid;
            mem_wd.activity = req_r.timestamp;
            mem_wd.execs    = (rd_q.execs == EXEC_MAX) ? EXEC_MAX : rd_q.execs + EXEC_W'(1);
            out_nxt.status    = STS_UPDATED;
            out_nxt.run_count = mem_wd.execs;
          end else begin
            out_nxt.status        = STS_FOUND;
            out_nxt.parent_id     = rd_q.parent;
            out_nxt.user_id       = rd_q.user;
            out_nxt.group_id      = rd_q.group;
            out_nxt.start_time    = rd_q.start;
            out_nxt.last_activity = rd_q.activity;
            out_nxt.run_count     = rd_q.execs;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_item_t'{action: action_t'(in_if.action), pid: in_if.pid, ppid: in_if.ppid,
                         uid: in_if.uid, gid: in_if.gid, timestamp: in_if.timestamp};
      hit_r <= hit_nxt;
    end
    if (rd_en) idx_r <= hit_idx;
    if (key_we) key_r[free_idx] <= req_r.pid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clr_all) begin
      valid_r <= '0;
    end else if (set_valid) begin
      valid_r[vld_idx] <= 1'b1;
    end else if (clr_valid) begin
      valid_r[vld_idx] <= 1'b0;
    end
  end

  // payload memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (rd_en) rd_q <= mem[hit_idx];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_data_r <= out_nxt;
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.status        = out_data_r.status;
  assign out_if.slot          = out_data_r.slot;
  assign out_if.parent_id     = out_data_r.parent_id;
  assign out_if.user_id       = out_data_r.user_id;
  assign out_if.group_id      = out_data_r.group_id;
  assign out_if.start_time    = out_data_r.start_time;
  assign out_if.last_activity = out_data_r.last_activity;
  assign out_if.run_count     = out_data_r.run_count;

  // keys of valid entries are unique, so at most one match
  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENC) |-> $onehot0(hit_r))
    else $error("more than one valid entry matches the key");

  a_accept_enc: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_ENC))
    else $error("request beat did not start the match");

  a_clear_all: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ENC && req_r.action == ACT_CLEAR && fire) |=> (valid_r == '0))
    else $error("clear left valid entries");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status == STS_INSERTED) |-> (out_data_r.run_count == 16'd1))
    else $error("insert result with exec count other than one");

endmodule

`default_nettype wire

FILE: verif/process_id_keyed_table_top_tb.sv
// Self-checking testbench for process_id_keyed_table_top: directed table, fill-to-full,
// back-to-back exec updates and random keyed traffic, with an in-house table predictor.
// Depends on rtl/pikt_pkg.sv, rtl/pikt_if.sv and rtl/process_id_keyed_table_top.sv.

module process_id_keyed_table_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pikt_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RAND_ITEMS  = 1244;
  localparam int QUIET_FROM  = 1100;  // no idling on either side after this many random beats
  localparam int POOL_MAX    = 128;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  pikt_in_if  in_ch();
  pikt_out_if out_ch();

  process_id_keyed_table_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // predictor copy of the table
  bit                tbl_live     [TABLE_ENTRIES];
  logic [ID_W-1:0]   tbl_key      [TABLE_ENTRIES];
  logic [ID_W-1:0]   tbl_parent   [TABLE_ENTRIES];
  logic [ID_W-1:0]   tbl_user     [TABLE_ENTRIES];
  logic [ID_W-1:0]   tbl_group    [TABLE_ENTRIES];
  logic [TS_W-1:0]   tbl_start    [TABLE_ENTRIES];
  logic [TS_W-1:0]   tbl_activity [TABLE_ENTRIES];
  logic [EXEC_W-1:0] tbl_execs    [TABLE_ENTRIES];

  out_item_t       pending_results[$];
  dir_row_t        dir_rows[$];
  logic [ID_W-1:0] key_pool [POOL_MAX];

  bit src_idle;
  bit snk_idle;
  int fail_cnt;
  int beats_sent;
  int cycle_cnt;
  int sts_seen [8];

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // applies one request to the predictor table and returns the result it should give
  function automatic out_item_t lookup_update(input in_item_t r);
    out_item_t res;
    int        hit;
    int        spare;
    res   = '0;
    hit   = -1;
    spare = -1;
    // walk downward so the lowest matching / free slot wins
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (tbl_live[i] && tbl_key[i] == r.pid) hit = i;
      if (!tbl_live[i]) spare = i;
    end
    case (r.action)
      ACT_ADD: begin
        if (hit >= 0) begin
          if (tbl_execs[hit] != EXEC_MAX) tbl_execs[hit] = tbl_execs[hit] + EXEC_W'(1);
          tbl_parent[hit]   = r.ppid;
          tbl_user[hit]     = r.uid;
          tbl_group[hit]    = r.gid;
          tbl_activity[hit] = r.timestamp;
          res.status        = STS_UPDATED;
          res.slot          = SLOT_W'(hit);
          res.run_count     = tbl_execs[hit];
        end else if (spare < 0) begin
          res.status = STS_FULL;
        end else begin
          tbl_live[spare]     = 1'b1;
          tbl_key[spare]      = r.pid;
          tbl_parent[spare]   = r.ppid;
          tbl_user[spare]     = r.uid;
          tbl_group[spare]    = r.gid;
          tbl_start[spare]    = r.timestamp;
          tbl_activity[spare] = r.timestamp;
          tbl_execs[spare]    = EXEC_W'(1);
          res.status          = STS_INSERTED;
          res.slot            = SLOT_W'(spare);
          res.run_count       = EXEC_W'(1);
        end
      end
      ACT_CLEAR: begin
        foreach (tbl_live[i]) tbl_live[i] = 1'b0;
        res.status = STS_CLEARED;
      end
      default: begin
        if (hit < 0) begin
          res.status = STS_NOTFOUND;
        end else if (r.action == ACT_REMOVE) begin
          tbl_live[hit] = 1'b0;
          res.status    = STS_REMOVED;
          res.slot      = SLOT_W'(hit);
        end else begin
          res.status        = STS_FOUND;
          res.slot          = SLOT_W'(hit);
          res.parent_id     = tbl_parent[hit];
          res.user_id       = tbl_user[hit];
          res.group_id      = tbl_group[hit];
          res.start_time    = tbl_start[hit];
          res.last_activity = tbl_activity[hit];
          res.run_count     = tbl_execs[hit];
        end
      end
    endcase
    return res;
  endfunction

  function automatic in_item_t mk_req(input action_t a, input logic [ID_W-1:0] pid,
                                      input logic [ID_W-1:0] ppid, input logic [ID_W-1:0] uid,
                                      input logic [ID_W-1:0] gid, input logic [TS_W-1:0] ts);
    in_item_t r;
    r.action    = a;
    r.pid       = pid;
    r.ppid      = ppid;
    r.uid       = uid;
    r.gid       = gid;
    r.timestamp = ts;
    return r;
  endfunction

  function automatic out_item_t mk_res(input status_t s, input int sl, input int ex);
    out_item_t w;
    w           = '0;
    w.status    = s;
    w.slot      = SLOT_W'(sl);
    w.run_count = EXEC_W'(ex);
    return w;
  endfunction

  // For a typed find hit, the payload columns of the row carry the stored fields
  // expected back (timestamp stands for both start and last activity).
  function automatic void put_row(input action_t a, input logic [ID_W-1:0] pid,
                                  input logic [ID_W-1:0] ppid, input logic [ID_W-1:0] uid,
                                  input logic [ID_W-1:0] gid, input logic [TS_W-1:0] ts,
                                  input int typed, input status_t s,
                                  input int sl, input int ex);
    dir_row_t row;
    row.req   = mk_req(a, pid, ppid, uid, gid, ts);
    row.typed = (typed != 0);
    row.want  = mk_res(s, sl, ex);
    if (typed != 0 && s == STS_FOUND) begin
      row.want.parent_id     = ppid;
      row.want.user_id       = uid;
      row.want.group_id      = gid;
      row.want.start_time    = ts;
      row.want.last_activity = ts;
    end
    dir_rows.push_back(row);
  endfunction

  function automatic in_item_t rand_req(input action_t a, input logic [ID_W-1:0] pid);
    return mk_req(a, pid, $urandom, $urandom, $urandom, {$urandom, $urandom});
  endfunction

  // one request beat; the expectation is queued at the accepting edge
  task automatic send(input in_item_t r, input int typed, input out_item_t want);
    out_item_t pred;
    if (src_idle && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.action    <= r.action;
    in_ch.pid       <= r.pid;
    in_ch.ppid      <= r.ppid;
    in_ch.uid       <= r.uid;
    in_ch.gid       <= r.gid;
    in_ch.timestamp <= r.timestamp;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    pred = lookup_update(r);
    pending_results.push_back((typed != 0) ? want : pred);
    beats_sent++;
  endtask

  function automatic int field_diff(input string name, input logic [63:0] want_v,
                                    input logic [63:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  // result side ready, with stall bursts
  initial begin : sink_side
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (snk_idle && $urandom_range(0, 4) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t got;
    out_item_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.status        = status_t'(out_ch.status);
      got.slot          = out_ch.slot;
      got.parent_id     = out_ch.parent_id;
      got.user_id       = out_ch.user_id;
      got.group_id      = out_ch.group_id;
      got.start_time    = out_ch.start_time;
      got.last_activity = out_ch.last_activity;
      got.run_count     = out_ch.run_count;
      sts_seen[got.status]++;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, status %0d slot %0d",
                 $time, got.status, got.slot);
        fail_cnt++;
      end else begin
        want = pending_results.pop_front();
        fail_cnt += field_diff("status", 64'(want.status), 64'(got.status))
                  + field_diff("slot", 64'(want.slot), 64'(got.slot))
                  + field_diff("parent_id", 64'(want.parent_id), 64'(got.parent_id))
                  + field_diff("user_id", 64'(want.user_id), 64'(got.user_id))
                  + field_diff("group_id", 64'(want.group_id), 64'(got.group_id))
                  + field_diff("start_time", want.start_time, got.start_time)
                  + field_diff("last_activity", want.last_activity, got.last_activity)
                  + field_diff("run_count", 64'(want.run_count), 64'(got.run_count));
      end
    end
  end

  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_cnt, pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [ID_W-1:0] fill_base;
    logic [ID_W-1:0] sat_pid;
    in_item_t        r;
    int              n_rand;
    int              seg_len;
    int              pool_n;
    int              roll;

    fail_cnt        = 0;
    beats_sent      = 0;
    src_idle        = 1'b1;
    snk_idle        = 1'b1;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.action    <= ACT_ADD;
    in_ch.pid       <= '0;
    in_ch.ppid      <= '0;
    in_ch.uid       <= '0;
    in_ch.gid       <= '0;
    in_ch.timestamp <= '0;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: empty-table misses, extremes, update, remove, lowest free slot
    put_row(ACT_FIND,   '0, '0, '0, '0, '0, 1, STS_NOTFOUND, 0, 0);
    put_row(ACT_REMOVE, '1, '1, '1, '1, '1, 1, STS_NOTFOUND, 0, 0);
    put_row(ACT_CLEAR,  '1, '1, '1, '1, '1, 1, STS_CLEARED, 0, 0);
    put_row(ACT_ADD,    '0, '0, '0, '0, '0, 1, STS_INSERTED, 0, 1);
    put_row(ACT_ADD,    '1, '1, '1, '1, '1, 1, STS_INSERTED, 1, 1);
    put_row(ACT_FIND,   '1, '1, '1, '1, '1, 1, STS_FOUND, 1, 1);
    put_row(ACT_FIND,   '0, '0, '0, '0, '0, 1, STS_FOUND, 0, 1);
    put_row(ACT_ADD,    '0, 32'h1234_5678, 32'h9abc_def0, 32'h0f0f_f0f0,
            64'h0123_4567_89ab_cdef, 1, STS_UPDATED, 0, 2);
    put_row(ACT_FIND,   '0, '0, '0, '0, '0, 0, STS_FOUND, 0, 0);
    put_row(ACT_ADD,    '1, '0, '0, '0, '0, 1, STS_UPDATED, 1, 2);
    put_row(ACT_FIND,   '1, '0, '0, '0, '0, 0, STS_FOUND, 0, 0);
    put_row(ACT_REMOVE, '0, '1, '1, '1, '1, 1, STS_REMOVED, 0, 0);
    put_row(ACT_FIND,   '0, '0, '0, '0, '0, 1, STS_NOTFOUND, 0, 0);
    put_row(ACT_REMOVE, '0, '0, '0, '0, '0, 1, STS_NOTFOUND, 0, 0);
    put_row(ACT_ADD,    32'h8000_0001, $urandom, $urandom, $urandom, {$urandom, $urandom},
            1, STS_INSERTED, 0, 1);
    put_row(ACT_ADD,    32'h7fff_fffe, $urandom, $urandom, $urandom, {$urandom, $urandom},
            1, STS_INSERTED, 2, 1);
    put_row(ACT_FIND,   32'h7fff_fffe, '0, '0, '0, '0, 0, STS_FOUND, 0, 0);
    put_row(ACT_REMOVE, '1, '0, '0, '0, '0, 1, STS_REMOVED, 1, 0);
    put_row(ACT_ADD,    32'h0000_0001, $urandom, $urandom, $urandom, {$urandom, $urandom},
            1, STS_INSERTED, 1, 1);
    put_row(ACT_FIND,   32'h0000_0001, '0, '0, '0, '0, 0, STS_FOUND, 0, 0);
    put_row(ACT_CLEAR,  '0, '0, '0, '0, '0, 1, STS_CLEARED, 0, 0);
    put_row(ACT_FIND,   32'h8000_0001, '0, '0, '0, '0, 1, STS_NOTFOUND, 0, 0);
    put_row(ACT_ADD,    32'h8000_0001, $urandom, $urandom, $urandom, {$urandom, $urandom},
            1, STS_INSERTED, 0, 1);
    foreach (dir_rows[i]) send(dir_rows[i].req, int'(dir_rows[i].typed), dir_rows[i].want);

    // fill every slot, then hit the full table; i*0x04000001 keeps keys distinct
    fill_base = $urandom;
    send(rand_req(ACT_CLEAR, fill_base), 1, mk_res(STS_CLEARED, 0, 0));
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      send(rand_req(ACT_ADD, fill_base ^ (i * 32'h0400_0001)), 1,
           mk_res(STS_INSERTED, i, 1));
    end
    send(rand_req(ACT_ADD, fill_base ^ (64 * 32'h0400_0001)), 1, mk_res(STS_FULL, 0, 0));
    send(rand_req(ACT_ADD, fill_base ^ (10 * 32'h0400_0001)), 0, '0);
    send(rand_req(ACT_FIND, fill_base ^ (10 * 32'h0400_0001)), 0, '0);
    send(rand_req(ACT_REMOVE, fill_base ^ (37 * 32'h0400_0001)), 1, mk_res(STS_REMOVED, 37, 0));
    send(rand_req(ACT_ADD, fill_base ^ (64 * 32'h0400_0001)), 1, mk_res(STS_INSERTED, 37, 1));
    send(rand_req(ACT_ADD, fill_base ^ (65 * 32'h0400_0001)), 1, mk_res(STS_FULL, 0, 0));

    // back-to-back adds on one id, counting the exec total up
    src_idle = 1'b0;
    snk_idle = 1'b0;
    sat_pid  = $urandom;
    send(rand_req(ACT_CLEAR, sat_pid), 1, mk_res(STS_CLEARED, 0, 0));
    send(rand_req(ACT_ADD, sat_pid), 1, mk_res(STS_INSERTED, 0, 1));
    repeat (8) send(rand_req(ACT_ADD, sat_pid), 0, '0);
    send(rand_req(ACT_ADD, sat_pid), 1, mk_res(STS_UPDATED, 0, 10));
    send(rand_req(ACT_FIND, sat_pid), 0, '0);

    // random segments over key pools of varied size; the largest pool overfills the table
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      case ($urandom_range(0, 3))
        0:       pool_n = 4;
        1:       pool_n = 12;
        2:       pool_n = 40;
        default: pool_n = 100;
      endcase
      seg_len  = (pool_n > TABLE_ENTRIES) ? 250 : $urandom_range(40, 160);
      src_idle = (n_rand < QUIET_FROM) && ($urandom_range(0, 2) != 0);
      snk_idle = (n_rand < QUIET_FROM) && ($urandom_range(0, 2) != 0);
      for (int k = 0; k < seg_len && n_rand < RAND_ITEMS; k++) begin
        if (n_rand >= QUIET_FROM) begin
          src_idle = 1'b0;
          snk_idle = 1'b0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
          // noise: any action on a random id, mostly misses
          r = rand_req(action_t'($urandom_range(0, 3)), $urandom);
        end else begin
          r = rand_req(ACT_ADD, key_pool[7'($urandom_range(0, pool_n - 1))]);
          if (roll >= 56 && roll < 72)      r.action = ACT_REMOVE;
          else if (roll >= 72 && roll < 98) r.action = ACT_FIND;
          else if (roll >= 98)              r.action = (pool_n > TABLE_ENTRIES) ? ACT_FIND
                                                                                : ACT_CLEAR;
        end
        send(r, 0, '0);
        n_rand++;
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d request beats: directed, fill-to-full, back-to-back updates, %0d random",
             beats_sent, n_rand);
    $display("results: %0d ins %0d upd %0d full %0d rem %0d miss %0d found %0d clr, %0d errors",
             sts_seen[STS_INSERTED], sts_seen[STS_UPDATED], sts_seen[STS_FULL],
             sts_seen[STS_REMOVED], sts_seen[STS_NOTFOUND], sts_seen[STS_FOUND],
             sts_seen[STS_CLEARED], fail_cnt);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/pikt_pkg.sv
rtl/pikt_if.sv
rtl/process_id_keyed_table_top.sv
verif/process_id_keyed_table_top_tb.sv
